### src/het_pkg.sv
// Package for the hysteresis edge trigger: widths, reset values and register indexes.
package het_pkg;

   localparam int MAX_LEN  = 4096;
   localparam int CNT_W    = $clog2(MAX_LEN + 1);
   localparam int POS_W    = 12;
   localparam int SAMPLE_W = 16;
   localparam int THR_W    = 15;
   localparam int HYS_W    = 12;
   localparam int BOUND_W  = SAMPLE_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = THR_W;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HYSTERESIS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION  = 2'd3;

   localparam logic [THR_W-1:0] THRESHOLD_RST  = 15'd2048;
   localparam logic [HYS_W-1:0] HYSTERESIS_RST = 12'd16;
   localparam logic             SLOPE_RST      = 1'b1;
   localparam logic             DIRECTION_RST  = 1'b0;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } result_type;

endpackage

### src/hysteresis_edge_trigger.sv
// Hysteresis edge trigger: per-sample arm/fire tracking with a registered result and skid stage.
//
//   channel | dir | handshake          | beat contents
//   req     | in  | tvalid/tready      | tdata: sample[15:0]; tlast: last sample of record
//   rsp     | out | tvalid/tready      | tdata: found[0], position[12:1], zero[15:13]
//   csr     | in  | csr_we             | csr_index selects register, csr_wdata value
//
// One sample per clock unless req stalls; an in-range sample updates trigger state when taken.
// The result of a record is registered on its last beat, in the output or skid register.
// A skid register holds a second result, so req stalls only when both are occupied.
// Reset clears the record state and loads the register defaults.
module hysteresis_edge_trigger
   import het_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample[15:0]
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // found[0], position[12:1], zero pad
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [THR_W-1:0] threshold_ff;
   logic [HYS_W-1:0] hysteresis_ff;
   logic             slope_ff;
   logic             direction_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             armed_ff, armed_in;
   logic             fwd_found_ff, fwd_found_in;
   logic [POS_W-1:0] fwd_index_ff, fwd_index_in;
   logic             opp_valid_ff, opp_valid_in;
   logic [POS_W-1:0] opp_index_ff, opp_index_in;
   logic             rev_valid_ff, rev_valid_in;
   logic [POS_W-1:0] rev_index_ff, rev_index_in;

   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   logic             skid_valid_ff, skid_valid_in;
   result_type       skid_ff, skid_in;

   logic               req_beat, rsp_beat, new_result;
   logic [BOUND_W-1:0] upper, lower, sample_ext;
   logic               arm_side, fire_side, in_range;
   logic [POS_W-1:0]   idx;
   result_type         result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RST;
         hysteresis_ff <= HYSTERESIS_RST;
         slope_ff      <= SLOPE_RST;
         direction_ff  <= DIRECTION_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD:  threshold_ff  <= csr_wdata[THR_W-1:0];
            REG_HYSTERESIS: hysteresis_ff <= csr_wdata[HYS_W-1:0];
            REG_SLOPE:      slope_ff      <= csr_wdata[0];
            REG_DIRECTION:  direction_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = !skid_valid_ff;
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_beat   = rsp_tvalid && rsp_tready;

   // bounds without wrap, 17-bit signed
   assign upper = BOUND_W'(threshold_ff) + BOUND_W'(hysteresis_ff);
   assign lower = BOUND_W'(threshold_ff) - BOUND_W'(hysteresis_ff);
   assign sample_ext = {req_tdata[SAMPLE_W-1], req_tdata[SAMPLE_W-1:0]};

   assign arm_side  = slope_ff ? ($signed(sample_ext) <= $signed(lower))
                               : ($signed(sample_ext) >= $signed(upper));
   assign fire_side = slope_ff ? ($signed(sample_ext) >= $signed(upper))
                               : ($signed(sample_ext) <= $signed(lower));
   assign in_range  = cnt_ff < CNT_W'(MAX_LEN);
   assign idx       = cnt_ff[POS_W-1:0];

   always_comb begin
      cnt_in       = cnt_ff;
      armed_in     = armed_ff;
      fwd_found_in = fwd_found_ff;
      fwd_index_in = fwd_index_ff;
      opp_valid_in = opp_valid_ff;
      opp_index_in = opp_index_ff;
      rev_valid_in = rev_valid_ff;
      rev_index_in = rev_index_ff;
      if (req_beat && in_range) begin
         if (!fwd_found_ff) begin
            armed_in = armed_ff || arm_side;
            if (armed_in && fire_side) begin
               fwd_found_in = 1'b1;
               fwd_index_in = idx;
            end
         end
         if (cnt_ff != '0) begin
            if (arm_side) begin
               opp_valid_in = 1'b1;
               opp_index_in = idx;
            end
            if (fire_side) begin
               rev_valid_in = opp_valid_in;
               rev_index_in = opp_index_in;
            end
         end
         cnt_in = cnt_ff + 1'b1;
      end
      result.found    = direction_ff ? rev_valid_in : fwd_found_in;
      result.position = result.found ? (direction_ff ? rev_index_in : fwd_index_in) : '0;
      new_result      = req_beat && req_tlast;
   end

   // output register and skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_beat) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (new_result) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || new_result) begin
         cnt_ff       <= '0;
         armed_ff     <= 1'b0;
         fwd_found_ff <= 1'b0;
         fwd_index_ff <= '0;
         opp_valid_ff <= 1'b0;
         opp_index_ff <= '0;
         rev_valid_ff <= 1'b0;
         rev_index_ff <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         armed_ff     <= armed_in;
         fwd_found_ff <= fwd_found_in;
         fwd_index_ff <= fwd_index_in;
         opp_valid_ff <= opp_valid_in;
         opp_index_ff <= opp_index_in;
         rev_valid_ff <= rev_valid_in;
         rev_index_ff <= rev_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_ff.position, out_ff.found});

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while output register is empty");

   a_no_pos_when_missing: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.found) |-> (out_ff.position == '0))
      else $error("position nonzero without a found edge");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_LEN))
      else $error("sample count past record limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      new_result |=> (cnt_ff == '0 && !armed_ff && !opp_valid_ff && out_valid_ff))
      else $error("record state not cleared or result missing after last beat");

endmodule
